>>> src/ptm_pkg.sv
// Shared types and codes for the periodic task tick monitor.
// Used by the controller, the datapath and the top level.
package ptm_pkg;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_TICK  = 3'd0;
    localparam mode_t MODE_LOAD  = 3'd1;
    localparam mode_t MODE_STATE = 3'd2;
    localparam mode_t MODE_CUR   = 3'd3;
    localparam mode_t MODE_WORK  = 3'd4;

    typedef logic [1:0] tstate_t;
    localparam tstate_t ST_SUSPENDED = 2'd0;
    localparam tstate_t ST_READY     = 2'd1;
    localparam tstate_t ST_RUNNING   = 2'd2;

    localparam logic [15:0] MISS_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CHARGE,
        OP_SCAN,
        OP_LOAD,
        OP_STATE,
        OP_WORK
    } op_t;

    typedef enum logic [1:0] {
        ASEL_CUR,
        ASEL_SCAN,
        ASEL_ITEM
    } asel_t;

    typedef struct packed {
        logic  load_in;
        logic  tick_inc;
        logic  rd_en;
        logic  wr_en;
        op_t   op;
        asel_t asel;
        logic  cur_write;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  item_ok;
        logic  cur_present;
        logic  out_busy;
    } status_t;

endpackage

>>> src/ptm_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing but the port widths of the monitor.
interface ptm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [2:0]  task_index;
    logic [31:0] period_value;
    logic [31:0] deadline_value;
    logic [31:0] first_release;
    logic [1:0]  new_state;
    logic [31:0] work_amount;
    logic        current_valid;

    modport source (output valid, mode, task_index, period_value, deadline_value,
                    first_release, new_state, work_amount, current_valid, input ready);
    modport sink (input valid, mode, task_index, period_value, deadline_value,
                  first_release, new_state, work_amount, current_valid, output ready);
endinterface

interface ptm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  released_mask;
    logic [7:0]  missed_mask;
    logic [31:0] tick_now;
    logic [1:0]  sel_state;
    logic [31:0] sel_exec_time;
    logic [31:0] sel_work_left;
    logic [31:0] sel_invocations;
    logic [15:0] sel_misses;
    logic [31:0] sel_wcet;
    logic [31:0] sel_total_exec;

    modport source (output valid, released_mask, missed_mask, tick_now, sel_state,
                    sel_exec_time, sel_work_left, sel_invocations, sel_misses,
                    sel_wcet, sel_total_exec, input ready);
    modport sink (input valid, released_mask, missed_mask, tick_now, sel_state,
                  sel_exec_time, sel_work_left, sel_invocations, sel_misses,
                  sel_wcet, sel_total_exec, output ready);
endinterface

>>> src/periodic_task_tick_monitor_top.sv
// Periodic task tick monitor, top level: APB configuration registers, the
// sequencer and the task table datapath. Depends on ptm_pkg, ptm_if and below.

// The monitor keeps a table of NUM_TASKS tasks and handles one item at a time,
// giving exactly one result transfer per input transfer. A tick item first
// charges the current task when one is selected and then walks the first n
// entries, where n is active_tasks limited to NUM_TASKS. The walk is set
// by the single task table memory, which is read and then written back once
// per visited entry. Load, set state and set work items with a valid task
// index read that entry and write it back; the other items write no entry.
// A new item is taken as soon as the previous one has been placed in the
// result register, even if that result has not been taken yet. The table
// needs no clearing pass after reset: per-entry valid bits make unwritten
// entries read as cleared, suspended tasks. Registers active_tasks (address
// 0) and the skipped-entry register (address 4) are written and read through
// the APB port and must only be written while the block is idle.
module periodic_task_tick_monitor_top
    import ptm_pkg::*;
#(
    parameter int NUM_TASKS  = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ptm_in_if.sink      in_ch,
    ptm_out_if.source   out_ch
);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int IW = $clog2(NUM_TASKS);

    logic [3:0]    active_reg;
    logic [3:0]    idle_reg;
    logic [CW-1:0] scan_limit;
    logic [IW-1:0] scan_idx;
    logic          in_ready;
    cmd_t          cmd;
    status_t       status;

    // Configuration registers. The address bit above the word offset picks
    // the register; a write lands at the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 4'd0;
            idle_reg   <= 4'd8;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                idle_reg <= pwdata[3:0];
            else
                active_reg <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {28'd0, idle_reg} : {28'd0, active_reg};

    // Number of entries the tick walk visits; larger settings act as the
    // full table.
    assign scan_limit = (int'(active_reg) > NUM_TASKS) ? CW'(NUM_TASKS) : CW'(active_reg);

    assign in_ch.ready = in_ready;

    ptm_ctrl #(
        .NUM_TASKS (NUM_TASKS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ready),
        .status     (status),
        .scan_limit (scan_limit),
        .cmd        (cmd),
        .scan_idx   (scan_idx)
    );

    ptm_dp #(
        .NUM_TASKS  (NUM_TASKS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cmd       (cmd),
        .scan_idx  (scan_idx),
        .skip_task (idle_reg),
        .status    (status)
    );

`ifndef SYNTHESIS
    // After an input transfer the block is busy for at least the decode cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ready) |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    // A task released on a tick cannot also be flagged late on that tick.
    a_rel_miss_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.released_mask & out_ch.missed_mask) == 8'd0))
        else $error("task both released and late in one result");

    // The table is only written while an item is being worked on.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !in_ready)
        else $error("table written while idle");
`endif

endmodule

>>> src/ptm_ctrl.sv
// Sequencer of the monitor: decodes an item and walks the task table.
// Depends on ptm_pkg.
module ptm_ctrl
    import ptm_pkg::*;
#(
    parameter int NUM_TASKS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  status_t                          status,
    input  logic [$clog2(NUM_TASKS+1)-1:0]   scan_limit,
    output cmd_t                             cmd,
    output logic [$clog2(NUM_TASKS)-1:0]     scan_idx
);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int IW = $clog2(NUM_TASKS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHG_RD,
        S_CHG_WR,
        S_SCAN_RD,
        S_SCAN_WR,
        S_OP_RD,
        S_OP_WR,
        S_RES_RD,
        S_RES_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] cnt_inc;

    assign cnt_inc  = cnt_reg + CW'(1);
    assign scan_idx = cnt_reg[IW-1:0];
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.asel   = ASEL_ITEM;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next = '0;
                case (status.mode)
                    MODE_TICK:
                    begin
                        cmd.tick_inc = 1'b1;
                        if (status.cur_present)
                            state_next = S_CHG_RD;
                        else if (scan_limit != '0)
                            state_next = S_SCAN_RD;
                        else
                            state_next = S_RES_RD;
                    end
                    MODE_LOAD, MODE_STATE, MODE_WORK:
                        state_next = status.item_ok ? S_OP_RD : S_RES_RD;
                    MODE_CUR:
                    begin
                        cmd.cur_write = 1'b1;
                        state_next    = S_RES_RD;
                    end
                    default:
                        state_next = S_RES_RD;
                endcase
            end
            S_CHG_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.asel   = ASEL_CUR;
                state_next = S_CHG_WR;
            end
            S_CHG_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.op     = OP_CHARGE;
                state_next = (scan_limit != '0) ? S_SCAN_RD : S_RES_RD;
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.asel   = ASEL_SCAN;
                state_next = S_SCAN_WR;
            end
            S_SCAN_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.op     = OP_SCAN;
                cnt_next   = cnt_inc;
                state_next = (cnt_inc == scan_limit) ? S_RES_RD : S_SCAN_RD;
            end
            S_OP_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_OP_WR;
            end
            S_OP_WR:
            begin
                cmd.wr_en = 1'b1;
                case (status.mode)
                    MODE_LOAD:  cmd.op = OP_LOAD;
                    MODE_STATE: cmd.op = OP_STATE;
                    MODE_WORK:  cmd.op = OP_WORK;
                    default:    cmd.op = OP_NONE;
                endcase
                state_next = S_RES_RD;
            end
            S_RES_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_RES_OUT;
            end
            S_RES_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> src/ptm_dp.sv
// Datapath of the monitor: task table memory, tick counter, entry update
// logic and the result register. Depends on ptm_pkg and ptm_if.
module ptm_dp
    import ptm_pkg::*;
#(
    parameter int NUM_TASKS  = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ptm_in_if.sink                        in_ch,
    ptm_out_if.source                     out_ch,
    input  cmd_t                          cmd,
    input  logic [$clog2(NUM_TASKS)-1:0]  scan_idx,
    input  logic [3:0]                    skip_task,
    output status_t                       status
);
    localparam int TW = TIME_WIDTH;
    localparam int IW = $clog2(NUM_TASKS);
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    typedef struct packed {
        tstate_t        st;
        logic [TW-1:0]  period;
        logic [TW-1:0]  rdl;
        logic [TW-1:0]  nrt;
        logic [TW-1:0]  adt;
        logic [TW-1:0]  exec;
        logic [TW-1:0]  total;
        logic [TW-1:0]  work;
        logic [TW-1:0]  worst;
        logic [TW-1:0]  rel;
        logic [15:0]    miss;
    } entry_t;

    function automatic logic [TW-1:0] fit_in(input logic [31:0] v);
        logic [TW+31:0] ext;
        ext = {{TW{1'b0}}, v};
        return ext[TW-1:0];
    endfunction

    function automatic logic [31:0] fit_out(input logic [TW-1:0] v);
        logic [TW+31:0] ext;
        ext = {32'd0, v};
        return ext[31:0];
    endfunction

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? TMAX : s[TW-1:0];
    endfunction

    // Latched item
    mode_t         mode_reg;
    logic [2:0]    idx_reg;
    logic [31:0]   period_reg, deadline_reg, first_reg, work_in_reg;
    tstate_t       nstate_reg;
    logic          cv_reg;

    logic [TW-1:0] tick_reg;
    logic [IW-1:0] cur_idx_reg;
    logic          cur_present_reg;

    entry_t        mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] vld_reg;
    entry_t        rdata_reg;
    logic          rvld_reg;
    logic [IW-1:0] addr_reg;

    logic [7:0]    rel_mask_reg, miss_mask_reg;
    logic          out_valid_reg;

    logic          item_ok;
    logic [IW-1:0] item_addr;
    logic [IW-1:0] rd_addr;
    logic [IW+2:0] idx_ext;
    logic [IW+2:0] addr_ext;
    entry_t        e, nx;
    logic          rel_hit, miss_hit, skip, in_mask;

    assign item_ok = (int'(idx_reg) < NUM_TASKS);
    assign idx_ext = {{IW{1'b0}}, idx_reg};
    assign item_addr = item_ok ? idx_ext[IW-1:0] : '0;
    assign addr_ext = {3'b000, addr_reg};

    always_comb
    begin
        case (cmd.asel)
            ASEL_CUR:  rd_addr = cur_idx_reg;
            ASEL_SCAN: rd_addr = scan_idx;
            default:   rd_addr = item_addr;
        endcase
    end

    assign e       = rvld_reg ? rdata_reg : '0;
    assign skip    = (int'(addr_reg) == int'(skip_task));
    assign in_mask = (int'(addr_reg) < 8);

    always_comb
    begin
        nx       = e;
        rel_hit  = 1'b0;
        miss_hit = 1'b0;
        case (cmd.op)
            OP_CHARGE:
            begin
                if (e.st == ST_RUNNING)
                begin
                    nx.exec  = sat_add(e.exec, TW'(1));
                    nx.total = sat_add(e.total, TW'(1));
                    if (e.work != '0)
                        nx.work = e.work - TW'(1);
                    if (nx.exec > e.worst)
                        nx.worst = nx.exec;
                end
            end
            OP_SCAN:
            begin
                // A task released on this tick gets a deadline at or after the tick, and the
                // late check excludes it, so it cannot be late on the same tick.
                rel_hit = !skip && (e.period != '0) && (e.st == ST_SUSPENDED)
                          && (tick_reg == e.nrt);
                miss_hit = !skip && !rel_hit && !((e.period == '0) && (e.rdl == '0))
                           && ((e.st == ST_RUNNING) || (e.st == ST_READY))
                           && (e.adt != '0) && (tick_reg > e.adt) && (e.work != '0);
                if (rel_hit)
                begin
                    nx.nrt  = sat_add(tick_reg, e.period);
                    nx.adt  = sat_add(tick_reg, e.rdl);
                    nx.exec = '0;
                    if (e.rel != TMAX)
                        nx.rel = e.rel + TW'(1);
                    nx.st = ST_READY;
                end
                if (miss_hit)
                begin
                    if (e.miss != MISS_MAX)
                        nx.miss = e.miss + 16'd1;
                    nx.adt = TMAX;
                end
            end
            OP_LOAD:
            begin
                nx        = '0;
                nx.period = fit_in(period_reg);
                nx.rdl    = fit_in(deadline_reg);
                nx.nrt    = fit_in(first_reg);
            end
            OP_STATE: nx.st = nstate_reg;
            OP_WORK:  nx.work = fit_in(work_in_reg);
            default:  nx = e;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg     <= in_ch.mode;
            idx_reg      <= in_ch.task_index;
            period_reg   <= in_ch.period_value;
            deadline_reg <= in_ch.deadline_value;
            first_reg    <= in_ch.first_release;
            nstate_reg   <= in_ch.new_state;
            work_in_reg  <= in_ch.work_amount;
            cv_reg       <= in_ch.current_valid;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            addr_reg  <= rd_addr;
        end
        if (cmd.wr_en)
            mem[addr_reg] <= nx;
        if (cmd.out_load)
        begin
            out_ch.released_mask   <= rel_mask_reg;
            out_ch.missed_mask     <= miss_mask_reg;
            out_ch.tick_now        <= fit_out(tick_reg);
            out_ch.sel_state       <= item_ok ? e.st : ST_SUSPENDED;
            out_ch.sel_exec_time   <= item_ok ? fit_out(e.exec) : 32'd0;
            out_ch.sel_work_left   <= item_ok ? fit_out(e.work) : 32'd0;
            out_ch.sel_invocations <= item_ok ? fit_out(e.rel) : 32'd0;
            out_ch.sel_misses      <= item_ok ? e.miss : 16'd0;
            out_ch.sel_wcet        <= item_ok ? fit_out(e.worst) : 32'd0;
            out_ch.sel_total_exec  <= item_ok ? fit_out(e.total) : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            rvld_reg        <= 1'b0;
            tick_reg        <= '0;
            cur_idx_reg     <= '0;
            cur_present_reg <= 1'b0;
            rel_mask_reg    <= '0;
            miss_mask_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
                rvld_reg <= vld_reg[rd_addr];
            if (cmd.wr_en)
                vld_reg[addr_reg] <= 1'b1;
            if (cmd.tick_inc)
                tick_reg <= sat_add(tick_reg, TW'(1));
            if (cmd.cur_write)
            begin
                if (cv_reg)
                begin
                    if (item_ok)
                    begin
                        cur_idx_reg     <= item_addr;
                        cur_present_reg <= 1'b1;
                    end
                end
                else
                    cur_present_reg <= 1'b0;
            end
            if (cmd.load_in)
            begin
                rel_mask_reg  <= '0;
                miss_mask_reg <= '0;
            end
            else if (cmd.wr_en && in_mask)
            begin
                if (rel_hit)
                    rel_mask_reg[addr_ext[2:0]]  <= 1'b1;
                if (miss_hit)
                    miss_mask_reg[addr_ext[2:0]] <= 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign status.mode        = mode_reg;
    assign status.item_ok     = item_ok;
    assign status.cur_present = cur_present_reg;
    assign status.out_busy    = out_valid_reg;

endmodule
